// ----- design/olid_pkg.sv -----
// Package for the ordered list core: request/response types, command,
// status and cell mode codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package olid_pkg;

	// Command codes
	localparam logic [2:0] CMD_INS_HEAD = 3'd0;
	localparam logic [2:0] CMD_INS_TAIL = 3'd1;
	localparam logic [2:0] CMD_INS_KEY  = 3'd2;
	localparam logic [2:0] CMD_DEL_HEAD = 3'd3;
	localparam logic [2:0] CMD_DEL_TAIL = 3'd4;
	localparam logic [2:0] CMD_DEL_KEY  = 3'd5;

	// Status codes
	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_NOKEY = 2'd2;
	localparam logic [1:0] STAT_FULL  = 2'd3;

	// Cell update modes, broadcast along the chain
	localparam logic [2:0] MODE_HOLD     = 3'd0;
	localparam logic [2:0] MODE_INS_HEAD = 3'd1;
	localparam logic [2:0] MODE_INS_TAIL = 3'd2;
	localparam logic [2:0] MODE_INS_KEY  = 3'd3;
	localparam logic [2:0] MODE_DEL_HEAD = 3'd4;
	localparam logic [2:0] MODE_DEL_KEY  = 3'd5;

	typedef struct packed {
		logic [2:0]         cmd;
		logic signed [31:0] item_value;
		logic signed [31:0] search_key;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] removed_value;
		logic [4:0]         list_length;
	} rsp_t;

	// Broadcast control from the sequencer to every cell
	typedef struct packed {
		logic               cap;   // capture key match and tail flags
		logic [2:0]         mode;  // update applied this cycle
		logic signed [31:0] item;  // value to insert
		logic signed [31:0] key;   // key compared on capture
	} cell_ctl_t;

endpackage

`default_nettype wire

// ----- design/olid_cell.sv -----
// One cell of the ordered list chain: holds one element, compares it with
// the search key and shifts toward either neighbor. Depends on olid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module olid_cell import olid_pkg::*; #(
	parameter int CAPACITY = 16,
	parameter int IDX      = 0
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire cell_ctl_t                           ctl,
	input  wire logic [$clog2(CAPACITY+1)-1:0]       occ,
	input  wire logic signed [31:0]                  left_val,
	input  wire logic signed [31:0]                  right_val,
	input  wire logic                                seen_in,
	input  wire logic                                first_in,
	output logic signed [31:0]                       val,
	output logic                                     seen_out,
	output logic                                     first_out,
	output logic signed [31:0]                       tail_val
);

	localparam int OCC_W = $clog2(CAPACITY + 1);
	localparam logic [OCC_W-1:0] IDX_C = OCC_W'(IDX);

	logic signed [31:0] val_q;
	logic               hit_q;
	logic               tail_q;

	// Match and tail flags, taken when a request is accepted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			tail_q <= 1'b0;
		end else if (ctl.cap) begin
			hit_q  <= (val_q == ctl.key) && (IDX_C < occ);
			tail_q <= (IDX_C == occ - OCC_W'(1));
		end
	end

	// Element update: load, shift from left, shift from right or hold
	always_ff @(posedge clk) begin
		unique case (ctl.mode)
			MODE_INS_HEAD: val_q <= left_val;
			MODE_INS_TAIL: begin
				if (IDX_C == occ) val_q <= ctl.item;
			end
			MODE_INS_KEY: begin
				priority if (first_in) val_q <= ctl.item;
				else if (seen_in)      val_q <= left_val;
				else                   val_q <= val_q;   // at or ahead of the match
			end
			MODE_DEL_HEAD: val_q <= right_val;
			MODE_DEL_KEY: begin
				if (seen_in || hit_q) val_q <= right_val;
			end
			default: ;
		endcase
	end

	// First-match chain toward the tail
	assign seen_out  = seen_in | hit_q;
	assign first_out = hit_q & ~seen_in;
	assign val       = val_q;
	assign tail_val  = tail_q ? val_q : 32'sd0;

endmodule

`default_nettype wire

// ----- design/ordered_list_insert_delete_core.sv -----
// Top level of the ordered list core: request sequencer and chain of
// olid_cell elements. Depends on olid_pkg and olid_cell.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   A request (req: cmd, item_value, search_key) is taken at a rising edge
//   with start high and busy low. busy is then high for one cycle while the
//   chain applies the request, so a new request is not taken while one is applied.
//   The response (rsp: status, removed_value, list_length) appears with the
//   done strobe for exactly one cycle, registered by the sequencer as it
//   leaves its execute state.
//   The receiver cannot stall; a new request may be taken in the cycle
//   that done is shown.
//   The key compare in every cell is registered at accept, then the
//   first-match chain and the cell updates (a load or a one-position shift)
//   happen in the following cycle.
//   Reset (arst_n low) empties the list and drops busy and done; element
//   contents are not cleared and are never read before being written.
//   Keyed delete returns the key as removed value, being equal to it.
module ordered_list_insert_delete_core import olid_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire req_t req,
	output logic      busy,
	output logic      done,
	output rsp_t      rsp
);

	localparam int OCC_W = $clog2(CAPACITY + 1);
	localparam logic [OCC_W-1:0] CAP_C = OCC_W'(CAPACITY);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic             st_q;
	logic [OCC_W-1:0] occ_q;
	req_t             req_q;
	logic             done_q;
	rsp_t             rsp_q;

	cell_ctl_t          ctl;
	logic [2:0]         mode;
	logic [1:0]         status;
	logic signed [31:0] removed;
	logic [OCC_W-1:0]   occ_nxt;
	logic               accept;
	logic               found;
	logic signed [31:0] tail_any;

	logic signed [31:0] cval [CAPACITY];
	logic signed [31:0] ctail [CAPACITY];
	logic               seen [CAPACITY+1];
	logic               first [CAPACITY+1];

	assign accept = start && (st_q == ST_IDLE);
	assign busy   = (st_q == ST_EXEC);

	// Chain of cells
	assign seen[0]  = 1'b0;
	assign first[0] = 1'b0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [31:0] lv;
		logic signed [31:0] rv;
		if (i == 0) begin : g_lft
			assign lv = ctl.item;
		end else begin : g_lft
			assign lv = cval[i-1];
		end
		if (i == CAPACITY - 1) begin : g_rgt
			assign rv = cval[i];
		end else begin : g_rgt
			assign rv = cval[i+1];
		end
		olid_cell #(
			.CAPACITY(CAPACITY),
			.IDX     (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.occ      (occ_q),
			.left_val (lv),
			.right_val(rv),
			.seen_in  (seen[i]),
			.first_in (first[i]),
			.val      (cval[i]),
			.seen_out (seen[i+1]),
			.first_out(first[i+1]),
			.tail_val (ctail[i])
		);
	end

	assign found = seen[CAPACITY];

	// Tail element: at most one cell flags itself as tail, none when the list is empty
	always_comb begin
		tail_any = 32'sd0;
		for (int i = 0; i < CAPACITY; i++) begin
			tail_any = tail_any | ctail[i];
		end
	end

	// Decode the held request into a cell mode and a response
	always_comb begin
		mode    = MODE_HOLD;
		status  = STAT_DONE;
		removed = 32'sd0;
		occ_nxt = occ_q;
		unique case (req_q.cmd)
			CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_KEY: begin
				priority if (occ_q == CAP_C) begin
					status = STAT_FULL;
				end else if (req_q.cmd == CMD_INS_HEAD ||
				             (req_q.cmd == CMD_INS_KEY && occ_q == '0)) begin
					mode    = MODE_INS_HEAD;
					occ_nxt = occ_q + OCC_W'(1);
				end else if (req_q.cmd == CMD_INS_TAIL) begin
					mode    = MODE_INS_TAIL;
					occ_nxt = occ_q + OCC_W'(1);
				end else if (found) begin
					mode    = MODE_INS_KEY;
					occ_nxt = occ_q + OCC_W'(1);
				end else begin
					status = STAT_NOKEY;
				end
			end
			CMD_DEL_HEAD, CMD_DEL_TAIL, CMD_DEL_KEY: begin
				priority if (occ_q == '0) begin
					status = STAT_EMPTY;
				end else if (req_q.cmd == CMD_DEL_HEAD) begin
					mode    = MODE_DEL_HEAD;
					removed = cval[0];
					occ_nxt = occ_q - OCC_W'(1);
				end else if (req_q.cmd == CMD_DEL_TAIL) begin
					removed = tail_any;
					occ_nxt = occ_q - OCC_W'(1);
				end else if (found) begin
					mode    = MODE_DEL_KEY;
					removed = req_q.search_key;
					occ_nxt = occ_q - OCC_W'(1);
				end else begin
					status = STAT_NOKEY;
				end
			end
			default: ;
		endcase
	end

	// Broadcast to the cells
	always_comb begin
		ctl.cap  = accept;
		ctl.mode = (st_q == ST_EXEC) ? mode : MODE_HOLD;
		ctl.item = req_q.item_value;
		ctl.key  = req.search_key;
	end

	// Sequencer, length and response registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			occ_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (start) st_q <= ST_EXEC;
				end
				ST_EXEC: begin
					st_q   <= ST_IDLE;
					occ_q  <= occ_nxt;
					done_q <= 1'b1;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) req_q <= req;
		if (st_q == ST_EXEC) begin
			rsp_q.status        <= status;
			rsp_q.removed_value <= removed;
			rsp_q.list_length   <= 5'(occ_nxt);
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// Checks
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CAP_C)
		else $error("element count above capacity");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted request not executed");

	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(st_q == ST_EXEC))
		else $error("response without execution");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && rsp_q.status == STAT_FULL) |-> rsp_q.list_length == 5'(CAPACITY))
		else $error("full status with list not full");

	a_empty_len: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && rsp_q.status == STAT_EMPTY) |-> rsp_q.list_length == 5'd0)
		else $error("empty status with list not empty");

endmodule

`default_nettype wire
